// ===== hdl/mlpr_pkg.sv =====
// Shared constants and control types for the monochrome LCD page refresh unit.
package mlpr_pkg;

   localparam int PAGES      = 8;
   localparam int COLUMNS    = 128;
   localparam int ROW_BYTES  = (COLUMNS + 7) / 8;
   localparam int STORE_SIZE = PAGES * 8 * ROW_BYTES;
   localparam int PAGE_LEN   = 3 + COLUMNS;

   localparam int REQ_ADDR_W = 10;
   localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int K_W        = $clog2(PAGE_LEN);

   localparam logic       REQ_WRITE      = 1'b0;
   localparam logic       REQ_STEP       = 1'b1;

   localparam logic [7:0] CMD_START_LINE = 8'h40;
   localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
   localparam logic [7:0] CMD_COL_HIGH   = 8'h10;
   localparam logic [7:0] CMD_COL_LOW    = 8'h00;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'hAF;

   typedef struct packed {
      logic clear_en;
      logic write_en;
      logic emit_cmd;
      logic gather_start;
      logic gather_en;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_free;
      logic need_gather;
      logic row_last;
   } dp_status_type;

endpackage

// ===== hdl/mono_lcd_page_refresh_unit.sv =====
// Top level of the monochrome LCD page refresh unit: controller joined to datapath.
// The unit holds a 64-row by 16-byte monochrome frame store and turns step requests
// into the page-mode refresh stream, one byte per step beat: start line, then for
// each page the page and column address commands and 128 column bytes, then the
// display-on byte flagged as last, after which the stream starts again. After reset
// the frame store is cleared one byte per cycle, so no request is taken until the
// clearing pass ends. A write beat gives no response; a step beat that yields a
// command byte is emitted straight from the idle state, and one that yields a column
// byte passes through the gather and finish states first, because its eight bits
// come from eight rows read in turn through the single port of the frame store.
// A request is taken only while the response register is empty or being drained.
module mono_lcd_page_refresh_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [mlpr_pkg::REQ_ADDR_W-1:0] req_addr,
   input  logic [7:0]                      req_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_is_data,
   output logic                            rsp_last
);
   import mlpr_pkg::*;

   ctrl_cmd_type  command;
   dp_status_type status;

   mlpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .command   (command)
   );

   mlpr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .command      (command),
      .status       (status),
      .req_addr     (req_addr),
      .req_wdata    (req_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== hdl/mlpr_ctrl.sv =====
// Controller state machine: clearing pass, item acceptance and column gathering.
module mlpr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   output logic                   req_ready,
   input  mlpr_pkg::dp_status_type status,
   output mlpr_pkg::ctrl_cmd_type  command
);
   import mlpr_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_GATHER = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      command  = '0;
      case (state_ff)
         ST_CLEAR: begin
            command.clear_en = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == REQ_WRITE) begin
                  command.write_en = 1'b1;
               end else if (status.need_gather) begin
                  command.gather_start = 1'b1;
                  state_in = ST_GATHER;
               end else begin
                  command.emit_cmd = 1'b1;
               end
            end
         end
         ST_GATHER: begin
            command.gather_en = 1'b1;
            if (status.row_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            command.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/mlpr_datapath.sv =====
// Datapath: frame store, stream position counters, column gather and result register.
module mlpr_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  mlpr_pkg::ctrl_cmd_type         command,
   output mlpr_pkg::dp_status_type        status,
   input  logic [mlpr_pkg::REQ_ADDR_W-1:0] req_addr,
   input  logic [7:0]                     req_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_is_data,
   output logic                           rsp_last
);
   import mlpr_pkg::*;

   localparam logic [1:0] SEG_START = 2'd0;
   localparam logic [1:0] SEG_BODY  = 2'd1;
   localparam logic [1:0] SEG_END   = 2'd2;

   logic [7:0]        mem [STORE_SIZE];
   logic [7:0]        rd_ff;
   logic              rd_vld_ff;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic [7:0]        mem_wdata;

   logic [ADDR_W-1:0] clr_ff;
   logic [1:0]        seg_ff;
   logic [1:0]        seg_in;
   logic [PAGE_W-1:0] page_ff;
   logic [PAGE_W-1:0] page_in;
   logic [K_W-1:0]    k_ff;
   logic [K_W-1:0]    k_in;
   logic [2:0]        r_ff;
   logic [7:0]        acc_ff;
   logic [K_W-1:0]    col;
   logic [ADDR_W-1:0] gather_addr;
   logic [2:0]        shift;
   logic              gbit;

   logic              rsp_valid_ff;
   logic [7:0]        out_byte_ff;
   logic              is_data_ff;
   logic              last_ff;
   logic [7:0]        cmd_byte;
   logic              cmd_last;
   logic              advance;

   assign col         = k_ff - K_W'(3);
   assign shift       = col[2:0];
   assign gather_addr = ADDR_W'((int'(page_ff) * 8 + int'(r_ff)) * ROW_BYTES
                                + int'(col >> 3));
   assign gbit        = rd_ff[shift];

   always_comb begin
      if (command.clear_en) begin
         mem_addr = clr_ff;
      end else if (command.gather_en) begin
         mem_addr = gather_addr;
      end else begin
         mem_addr = ADDR_W'(req_addr);
      end
      mem_we    = command.clear_en
                  || (command.write_en && (int'(req_addr) < STORE_SIZE));
      mem_wdata = command.clear_en ? 8'h00 : req_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

   always_comb begin
      cmd_byte = CMD_COL_LOW;
      cmd_last = 1'b0;
      case (seg_ff)
         SEG_START: cmd_byte = CMD_START_LINE;
         SEG_END: begin
            cmd_byte = CMD_DISPLAY_ON;
            cmd_last = 1'b1;
         end
         default: begin
            if (k_ff == K_W'(0)) begin
               cmd_byte = CMD_PAGE_BASE + 8'(page_ff);
            end else if (k_ff == K_W'(1)) begin
               cmd_byte = CMD_COL_HIGH;
            end else begin
               cmd_byte = CMD_COL_LOW;
            end
         end
      endcase
   end

   assign advance = command.emit_cmd || command.finish;

   always_comb begin
      seg_in  = seg_ff;
      page_in = page_ff;
      k_in    = k_ff;
      case (seg_ff)
         SEG_START: begin
            seg_in  = SEG_BODY;
            page_in = '0;
            k_in    = '0;
         end
         SEG_BODY: begin
            if (k_ff == K_W'(PAGE_LEN - 1)) begin
               k_in = '0;
               if (page_ff == PAGE_W'(PAGES - 1)) begin
                  seg_in = SEG_END;
               end else begin
                  page_in = page_ff + PAGE_W'(1);
               end
            end else begin
               k_in = k_ff + K_W'(1);
            end
         end
         default: begin
            seg_in = SEG_START;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         seg_ff       <= SEG_START;
         page_ff      <= '0;
         k_ff         <= '0;
         r_ff         <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (command.clear_en) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (advance) begin
            seg_ff  <= seg_in;
            page_ff <= page_in;
            k_ff    <= k_in;
         end
         if (command.gather_start) begin
            r_ff <= '0;
         end else if (command.gather_en) begin
            r_ff <= r_ff + 3'd1;
         end
         rd_vld_ff    <= command.gather_en;
         rsp_valid_ff <= advance || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         acc_ff <= {gbit, acc_ff[7:1]};
      end
      if (command.emit_cmd) begin
         out_byte_ff <= cmd_byte;
         is_data_ff  <= 1'b0;
         last_ff     <= cmd_last;
      end else if (command.finish) begin
         out_byte_ff <= {gbit, acc_ff[7:1]};
         is_data_ff  <= 1'b1;
         last_ff     <= 1'b0;
      end
   end

   assign status.clear_done  = (clr_ff == ADDR_W'(STORE_SIZE - 1));
   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign status.need_gather = (seg_ff == SEG_BODY) && (k_ff >= K_W'(3));
   assign status.row_last    = (r_ff == 3'd7);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_is_data  = is_data_ff;
   assign rsp_last     = last_ff;

endmodule

// ===== hdl/mlpr_checker.sv =====
// Port-level assertions for the page refresh unit, bound to the top level.
module mlpr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_cmd,
   input logic [mlpr_pkg::REQ_ADDR_W-1:0] req_addr,
   input logic [7:0]                      req_wdata,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [7:0]                      rsp_out_byte,
   input logic                            rsp_is_data,
   input logic                            rsp_last
);
   import mlpr_pkg::*;

   // A stalled request beat keeps its payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_cmd)
      && $stable(req_addr) && $stable(req_wdata))
      else $error("request beat changed while stalled");

   // A stalled response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
      && $stable(rsp_is_data) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // The closing beat is always the display-on command.
   a_last_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_byte == CMD_DISPLAY_ON && !rsp_is_data)
      else $error("last beat is not the display-on command");

   // The stream always restarts with the start-line command after the closing beat.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last
      |=> (rsp_valid && rsp_ready) [->1]
      ##0 (rsp_out_byte == CMD_START_LINE && !rsp_is_data && !rsp_last))
      else $error("stream did not restart with the start-line command");

   // The frame store is being cleared straight after reset, so no request is taken.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

endmodule

bind mono_lcd_page_refresh_unit mlpr_checker u_mlpr_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the monochrome LCD page refresh unit.
`timescale 1ns / 100ps

module tb_top;

   import mlpr_pkg::*;

   localparam int STREAM_LEN   = 2 + PAGES * PAGE_LEN;
   localparam int RANDOM_ITEMS = 1300;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic                  cmd;
      logic [REQ_ADDR_W-1:0] addr;
      logic [7:0]            wdata;
   } lcd_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       last;
   } lcd_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_cmd   = REQ_WRITE;
   logic [REQ_ADDR_W-1:0] req_addr  = '0;
   logic [7:0]            req_wdata = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_is_data;
   logic                  rsp_last;

   lcd_req_type  pending_reqs[$];
   lcd_beat_type expected_beats[$];
   lcd_req_type  next_req;

   logic [7:0]  frame_img [STORE_SIZE];
   int unsigned stream_pos;

   int   total_items;
   int   items_sent;
   logic req_beat_taken = 1'b0;
   int   stall_cycles;
   int   error_count;
   int   write_beats;
   int   step_beats;
   int   rsp_beats;
   int   refresh_count;
   int   hold_left;
   int   holds_done;
   int   gen_pos;
   int   gen_steps;

   mono_lcd_page_refresh_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_addr     (req_addr),
      .req_wdata    (req_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_last     (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] column_bits(input int unsigned page, input int unsigned col);
      logic [7:0]  acc;
      int unsigned idx;
      acc = '0;
      for (int r = 0; r < 8; r++) begin
         idx = (page * 8 + r) * ROW_BYTES + (col >> 3);
         if (idx < STORE_SIZE) begin
            acc[r] = frame_img[idx][col & 7];
         end
      end
      return acc;
   endfunction

   task automatic take_request(input lcd_req_type item);
      lcd_beat_type beat;
      int unsigned  seg;
      int unsigned  page;
      int unsigned  k;
      if (item.cmd == REQ_WRITE) begin
         if (item.addr < STORE_SIZE) begin
            frame_img[item.addr] = item.wdata;
         end
         write_beats++;
      end else begin
         beat = '0;
         if (stream_pos == 0) begin
            beat.out_byte = CMD_START_LINE;
         end else if (stream_pos == STREAM_LEN - 1) begin
            beat.out_byte = CMD_DISPLAY_ON;
            beat.last     = 1'b1;
         end else begin
            seg  = stream_pos - 1;
            page = seg / PAGE_LEN;
            k    = seg % PAGE_LEN;
            if (k == 0) begin
               beat.out_byte = CMD_PAGE_BASE + 8'(page);
            end else if (k == 1) begin
               beat.out_byte = CMD_COL_HIGH;
            end else if (k == 2) begin
               beat.out_byte = CMD_COL_LOW;
            end else begin
               beat.out_byte = column_bits(page, k - 3);
               beat.is_data  = 1'b1;
            end
         end
         stream_pos = (stream_pos + 1 == STREAM_LEN) ? 0 : stream_pos + 1;
         expected_beats.push_back(beat);
         step_beats++;
      end
   endtask

   task automatic queue_write(input int unsigned addr, input int unsigned data);
      lcd_req_type item;
      item.cmd   = REQ_WRITE;
      item.addr  = REQ_ADDR_W'(addr);
      item.wdata = 8'(data);
      pending_reqs.push_back(item);
   endtask

   task automatic queue_step(input int unsigned addr, input int unsigned data);
      lcd_req_type item;
      item.cmd   = REQ_STEP;
      item.addr  = REQ_ADDR_W'(addr);
      item.wdata = 8'(data);
      pending_reqs.push_back(item);
      gen_pos = (gen_pos + 1 == STREAM_LEN) ? 0 : gen_pos + 1;
      gen_steps++;
   endtask

   function automatic int sender_idle_pct();
      if (items_sent < total_items / 3) begin
         return 35;
      end else if (items_sent < 2 * total_items / 3) begin
         return 51;
      end
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (items_sent < total_items / 3) begin
         return 51;
      end else if (items_sent < 2 * total_items / 3) begin
         return 35;
      end
      return 0;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
            next_req = pending_reqs.pop_front();
            req_valid  <= 1'b1;
            req_cmd    <= next_req.cmd;
            req_addr   <= next_req.addr;
            req_wdata  <= next_req.wdata;
            items_sent <= items_sent + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The receiver stops twice for a long stretch so that the unit fills and refuses requests.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if ((holds_done == 0 && rsp_beats >= 150) ||
                   (holds_done == 1 && rsp_beats >= 950)) begin
         hold_left  = HOLD_CYCLES - 1;
         holds_done = holds_done + 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
   end

   always @(posedge clock) begin
      lcd_beat_type want;
      lcd_beat_type got;
      if (reset) begin
         req_beat_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_byte, rsp_is_data, rsp_last};
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected response out_byte=%h is_data=%b last=%b",
                        $time, got.out_byte, got.is_data, got.last);
               error_count++;
            end else begin
               want = expected_beats.pop_front();
               if (got !== want) begin
                  $display({"%0t: response mismatch: expected out_byte=%h is_data=%b ",
                            "last=%b, got out_byte=%h is_data=%b last=%b"},
                           $time, want.out_byte, want.is_data, want.last,
                           got.out_byte, got.is_data, got.last);
                  error_count++;
               end
            end
            if (got.last === 1'b1) begin
               refresh_count++;
            end
            rsp_beats++;
         end
         if (req_valid && req_ready) begin
            take_request({req_cmd, req_addr, req_wdata});
         end
         req_beat_taken <= req_valid && req_ready;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("mono_lcd_page_refresh_unit regression: fail");
      $finish;
   end

   initial begin
      int unsigned page;
      int unsigned row;
      int unsigned addr;
      int unsigned data;
      int          pick;
      int          n;

      foreach (frame_img[i]) begin
         frame_img[i] = '0;
      end

      queue_write(0, 8'h01);
      queue_write(7 * ROW_BYTES, 8'h80);
      queue_write(STORE_SIZE - 1, 8'hFF);
      queue_write(63 * ROW_BYTES, 8'hA5);
      queue_write(ROW_BYTES - 1, 8'h5A);
      queue_write(3 * ROW_BYTES, 8'hFF);
      for (int i = 0; i < 11; i++) begin
         queue_step((i & 1) ? STORE_SIZE - 1 : 0, (i & 1) ? 8'hFF : 8'h00);
      end
      queue_write(0, 8'hFE);
      queue_write(ROW_BYTES, 8'h00);
      queue_step(0, 8'h00);
      queue_step(STORE_SIZE - 1, 8'hFF);
      queue_step(512, 8'h80);

      n = 0;
      while (n < RANDOM_ITEMS || gen_steps < STREAM_LEN + 64) begin
         if ($urandom_range(0, 99) < 18) begin
            if ($urandom_range(0, 9) < 6) begin
               if (gen_pos >= 1 && gen_pos < STREAM_LEN - 1) begin
                  page = (gen_pos - 1) / PAGE_LEN;
               end else begin
                  page = $urandom_range(0, PAGES - 1);
               end
               row  = page * 8 + $urandom_range(0, 7);
               addr = row * ROW_BYTES + $urandom_range(0, ROW_BYTES - 1);
            end else begin
               addr = $urandom_range(0, STORE_SIZE - 1);
            end
            pick = $urandom_range(0, 9);
            data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : $urandom_range(0, 255);
            queue_write(addr, data);
         end else begin
            queue_step($urandom_range(0, (1 << REQ_ADDR_W) - 1), $urandom_range(0, 255));
         end
         n++;
      end
      total_items = pending_reqs.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_reqs.size() > 0 || req_valid || expected_beats.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d frame store writes and %0d refresh stream bytes, %0d full refreshes.",
               write_beats, step_beats, refresh_count);
      $display("Sender and receiver idled in both ratios and the receiver stalled %0d times.",
               holds_done);
      if (error_count == 0) begin
         $display("mono_lcd_page_refresh_unit regression: pass");
      end else begin
         $display("mono_lcd_page_refresh_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== mono_lcd_page_refresh_unit.f =====
hdl/mlpr_pkg.sv
hdl/mlpr_ctrl.sv
hdl/mlpr_datapath.sv
hdl/mono_lcd_page_refresh_unit.sv
hdl/mlpr_checker.sv
tb/tb_top.sv
